// ===== design/fea_pkg.sv =====
// ---------------------------------------------------------------------------
// fea_pkg
// Shared types and codes of the free extent allocator.
// ---------------------------------------------------------------------------
package fea_pkg;

  localparam int MaxRangesDef = 64;
  localparam int BlockBitsDef = 32;

  // action codes
  localparam logic [1:0] ACT_FREE    = 2'd0;
  localparam logic [1:0] ACT_ALIGNED = 2'd1;
  localparam logic [1:0] ACT_EXTENT  = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NOSPACE = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_HINT    = 3'd3;
  localparam logic [2:0] STAT_BAD     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_number;
    logic [31:0] block_count;
  } fea_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] start_block;
    logic [31:0] blocks_left;
    logic [32:0] free_total;
  } fea_out_t;

  typedef enum logic [3:0] {
    FS_IDLE, FS_SCAN_RD, FS_SCAN_EV, FS_DECIDE, FS_SH_RD, FS_SH_WR, FS_WR0, FS_WR1, FS_DONE
  } fea_state_e;

  typedef enum logic [1:0] {
    SH_NONE, SH_OPEN, SH_CLOSE
  } fea_shift_e;

endpackage

// ===== design/fea_table_mem.sv =====
// ---------------------------------------------------------------------------
// fea_table_mem
// Range table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fea_table_mem #(
  parameter int Depth = 64,
  parameter int Width = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/free_extent_allocator_unit.sv =====
// The scan reads the table one entry at a time, and an insert or delete shifts the
// table tail one entry at a time through the one read port and one write port.
// One item is in work at a time, and the input is not ready while it is; a
// finished result waits in the output register while the next item is taken. Reset
// empties the table and clears the free total at once; no clearing pass runs.
// ---------------------------------------------------------------------------
// free_extent_allocator_unit
// First-fit free extent list with coalescing, kept in a sorted range table.
// ---------------------------------------------------------------------------
module free_extent_allocator_unit import fea_pkg::*; #(
  parameter int MAX_RANGES = MaxRangesDef,
  parameter int BLOCK_BITS = BlockBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fea_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fea_out_t out_data_o
);

  localparam int CalcW = ((BLOCK_BITS > 32) ? BLOCK_BITS : 32) + 2;
  localparam int IdxW  = $clog2(MAX_RANGES);
  localparam int CntW  = $clog2(MAX_RANGES + 1);
  localparam int EntW  = 2 * BLOCK_BITS;

  typedef logic [CalcW-1:0] calc_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam calc_t SpaceMax = (calc_t'(1) << BLOCK_BITS) - calc_t'(1);
  localparam cnt_t  MaxCnt   = cnt_t'(MAX_RANGES);
  localparam calc_t One      = calc_t'(1);
  localparam cnt_t  COne     = cnt_t'(1);

  function automatic logic [EntW-1:0] pack_ent(calc_t lo, calc_t hi);
    return {lo[BLOCK_BITS-1:0], hi[BLOCK_BITS-1:0]};
  endfunction

  fea_state_e state_q, state_d;
  logic [1:0] act_q, act_d;
  calc_t      bn_q, bn_d, cnt_q, cnt_d;
  cnt_t       count_q, count_d, idx_q, idx_d;
  logic [32:0] total_q, total_d;
  calc_t      prev_lo_q, prev_lo_d, prev_hi_q, prev_hi_d;
  calc_t      cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic       prev_v_q, prev_v_d, cur_v_q, cur_v_d;
  fea_shift_e sh_mode_q, sh_mode_d;
  cnt_t       sh_q, sh_d, sh_end_q, sh_end_d;
  logic       w0_en_q, w0_en_d, w1_en_q, w1_en_d;
  cnt_t       w0_addr_q, w0_addr_d, w1_addr_q, w1_addr_d;
  logic [EntW-1:0] w0_data_q, w0_data_d, w1_data_q, w1_data_d;
  fea_out_t   res_q, res_d, out_q, out_d;
  cnt_t       count_nx_q, count_nx_d;
  logic [32:0] total_nx_q, total_nx_d;
  logic       out_valid_q, out_valid_d;

  // memory port
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;

  fea_table_mem #(
    .Depth(MAX_RANGES),
    .Width(EntW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata),
    .rd_addr_i(mem_raddr),
    .rd_data_o(mem_rdata)
  );

  calc_t ent_lo, ent_hi;
  assign ent_lo = calc_t'(mem_rdata[EntW-1:BLOCK_BITS]);
  assign ent_hi = calc_t'(mem_rdata[BLOCK_BITS-1:0]);

  // entry evaluation during the scan
  calc_t cnt_m1, free_hi, ev_a, ev_ah;
  logic  ev_fit, ev_last;
  assign cnt_m1  = cnt_q - One;
  assign free_hi = bn_q + cnt_m1;
  assign ev_a    = (ent_lo + cnt_m1) & ~cnt_m1;
  assign ev_ah   = ev_a + cnt_m1;
  assign ev_fit  = (ev_ah <= ent_hi);
  assign ev_last = ((idx_q + COne) == count_q);

  // plan for the located entry
  logic [2:0]  pl_status;
  calc_t       pl_start, pl_left, pl_sub;
  fea_shift_e  pl_sh;
  cnt_t        pl_sh_start, pl_sh_end, pl_count;
  logic        pl_w0_en, pl_w1_en, pl_add;
  cnt_t        pl_w0_addr, pl_w1_addr;
  logic [EntW-1:0] pl_w0_data, pl_w1_data;
  logic [32:0] pl_total;
  calc_t       dc_a, dc_ah, dc_s, dc_nh;
  logic        mp, mn, full;
  logic [33:0] add_sum;

  assign dc_a  = (cur_lo_q + cnt_m1) & ~cnt_m1;
  assign dc_ah = dc_a + cnt_m1;
  assign dc_s  = (bn_q == '0) ? cur_lo_q : bn_q;
  assign dc_nh = dc_s + cnt_m1;
  assign mp    = prev_v_q && ((prev_hi_q + One) == bn_q);
  assign mn    = cur_v_q && ((free_hi + One) == cur_lo_q);
  assign full  = (count_q == MaxCnt);
  assign add_sum = {1'b0, total_q} + {2'b00, cnt_q[31:0]};

  always_comb begin
    pl_status   = STAT_OK;
    pl_start    = '0;
    pl_left     = '0;
    pl_sh       = SH_NONE;
    pl_sh_start = '0;
    pl_sh_end   = '0;
    pl_count    = count_q;
    pl_w0_en    = 1'b0;
    pl_w0_addr  = idx_q;
    pl_w0_data  = '0;
    pl_w1_en    = 1'b0;
    pl_w1_addr  = idx_q;
    pl_w1_data  = pack_ent(cur_lo_q, dc_s - One);
    pl_add      = 1'b0;
    pl_sub      = '0;
    unique case (act_q)
      ACT_FREE: begin
        pl_add = 1'b1;
        if ((prev_v_q && prev_hi_q >= bn_q) || (cur_v_q && free_hi >= cur_lo_q)) begin
          pl_status = STAT_BAD;
        end else if (mp && mn) begin
          pl_w0_en   = 1'b1;
          pl_w0_addr = idx_q - COne;
          pl_w0_data = pack_ent(prev_lo_q, cur_hi_q);
          pl_count   = count_q - COne;
          pl_sh_start = idx_q + COne;
          pl_sh_end   = count_q - COne;
          if ((idx_q + COne) != count_q) pl_sh = SH_CLOSE;
        end else if (mp) begin
          pl_w0_en   = 1'b1;
          pl_w0_addr = idx_q - COne;
          pl_w0_data = pack_ent(prev_lo_q, free_hi);
        end else if (mn) begin
          pl_w0_en   = 1'b1;
          pl_w0_data = pack_ent(bn_q, cur_hi_q);
        end else if (full) begin
          pl_status = STAT_FULL;
        end else begin
          pl_w0_en    = 1'b1;
          pl_w0_data  = pack_ent(bn_q, free_hi);
          pl_count    = count_q + COne;
          pl_sh_start = count_q - COne;
          pl_sh_end   = idx_q;
          if (idx_q != count_q) pl_sh = SH_OPEN;
        end
      end
      ACT_ALIGNED: begin
        pl_start = dc_a;
        pl_sub   = cnt_q;
        pl_w1_data = pack_ent(cur_lo_q, dc_a - One);
        if (dc_a == cur_lo_q) begin
          if (dc_ah < cur_hi_q) begin
            pl_w0_en   = 1'b1;
            pl_w0_data = pack_ent(dc_ah + One, cur_hi_q);
          end else begin
            pl_count    = count_q - COne;
            pl_sh_start = idx_q + COne;
            pl_sh_end   = count_q - COne;
            if ((idx_q + COne) != count_q) pl_sh = SH_CLOSE;
          end
        end else if (dc_ah < cur_hi_q) begin
          if (full) begin
            pl_status = STAT_FULL;
          end else begin
            pl_w0_en    = 1'b1;
            pl_w0_addr  = idx_q + COne;
            pl_w0_data  = pack_ent(dc_ah + One, cur_hi_q);
            pl_w1_en    = 1'b1;
            pl_count    = count_q + COne;
            pl_sh       = SH_OPEN;
            pl_sh_start = count_q - COne;
            pl_sh_end   = idx_q;
          end
        end else begin
          pl_w0_en   = 1'b1;
          pl_w0_data = pack_ent(cur_lo_q, dc_a - One);
        end
      end
      default: begin
        pl_start = dc_s;
        if (dc_nh >= cur_hi_q) begin
          pl_left = dc_nh - cur_hi_q;
          if (dc_s == cur_lo_q) begin
            pl_count    = count_q - COne;
            pl_sh_start = idx_q + COne;
            pl_sh_end   = count_q - COne;
            if ((idx_q + COne) != count_q) pl_sh = SH_CLOSE;
          end else begin
            pl_w0_en   = 1'b1;
            pl_w0_data = pack_ent(cur_lo_q, dc_s - One);
          end
        end else if (dc_s != cur_lo_q) begin
          if (full) begin
            pl_status = STAT_FULL;
          end else begin
            pl_w0_en    = 1'b1;
            pl_w0_addr  = idx_q + COne;
            pl_w0_data  = pack_ent(dc_nh + One, cur_hi_q);
            pl_w1_en    = 1'b1;
            pl_count    = count_q + COne;
            pl_sh       = SH_OPEN;
            pl_sh_start = count_q - COne;
            pl_sh_end   = idx_q;
          end
        end else begin
          pl_w0_en   = 1'b1;
          pl_w0_data = pack_ent(dc_nh + One, cur_hi_q);
        end
        pl_sub = cnt_q - pl_left;
      end
    endcase
    if (pl_add) begin
      pl_total = add_sum[33] ? '1 : add_sum[32:0];
    end else if (pl_sub > calc_t'(total_q)) begin
      pl_total = '0;
    end else begin
      pl_total = total_q - pl_sub[32:0];
    end
  end

  // bad-request checks on the incoming item
  calc_t in_bn, in_cnt;
  logic  in_bad;
  assign in_bn  = calc_t'(in_data_i.block_number);
  assign in_cnt = calc_t'(in_data_i.block_count);
  assign in_bad = (in_cnt == '0) || (in_data_i.action > ACT_EXTENT)
               || ((in_data_i.action == ACT_ALIGNED) && ((in_cnt & (in_cnt - One)) != '0))
               || ((in_data_i.action == ACT_FREE) && ((in_bn + in_cnt - One) > SpaceMax));

  assign in_ready_o  = (state_q == FS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    bn_d       = bn_q;
    cnt_d      = cnt_q;
    count_d    = count_q;
    idx_d      = idx_q;
    total_d    = total_q;
    prev_lo_d  = prev_lo_q;
    prev_hi_d  = prev_hi_q;
    prev_v_d   = prev_v_q;
    cur_lo_d   = cur_lo_q;
    cur_hi_d   = cur_hi_q;
    cur_v_d    = cur_v_q;
    sh_mode_d  = sh_mode_q;
    sh_d       = sh_q;
    sh_end_d   = sh_end_q;
    w0_en_d    = w0_en_q;
    w0_addr_d  = w0_addr_q;
    w0_data_d  = w0_data_q;
    w1_en_d    = w1_en_q;
    w1_addr_d  = w1_addr_q;
    w1_data_d  = w1_data_q;
    res_d      = res_q;
    count_nx_d = count_nx_q;
    total_nx_d = total_nx_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we     = 1'b0;
    mem_waddr  = w0_addr_q[IdxW-1:0];
    mem_wdata  = w0_data_q;
    mem_raddr  = idx_q[IdxW-1:0];

    unique case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          act_d      = in_data_i.action;
          bn_d       = in_bn;
          cnt_d      = in_cnt;
          idx_d      = '0;
          prev_v_d   = 1'b0;
          cur_v_d    = 1'b0;
          count_nx_d = count_q;
          total_nx_d = total_q;
          res_d.status      = STAT_BAD;
          res_d.start_block = '0;
          res_d.blocks_left = '0;
          res_d.free_total  = total_q;
          if (in_bad) begin
            state_d = FS_DONE;
          end else if (count_q == '0) begin
            if (in_data_i.action == ACT_FREE) begin
              state_d = FS_DECIDE;
            end else begin
              res_d.status = STAT_NOSPACE;
              if (in_data_i.action == ACT_EXTENT) res_d.blocks_left = in_data_i.block_count;
              state_d = FS_DONE;
            end
          end else begin
            state_d = FS_SCAN_RD;
          end
        end
      end
      FS_SCAN_RD: begin
        state_d = FS_SCAN_EV;
      end
      FS_SCAN_EV: begin
        cur_lo_d = ent_lo;
        cur_hi_d = ent_hi;
        state_d  = FS_SCAN_RD;
        res_d.status = STAT_NOSPACE;
        if (act_q == ACT_EXTENT) res_d.blocks_left = cnt_q[31:0];
        priority case (act_q)
          ACT_FREE: begin
            if (ent_lo > bn_q) begin
              cur_v_d = 1'b1;
              state_d = FS_DECIDE;
            end else begin
              prev_lo_d = ent_lo;
              prev_hi_d = ent_hi;
              prev_v_d  = 1'b1;
              idx_d     = idx_q + COne;
              if (ev_last) state_d = FS_DECIDE;
            end
          end
          ACT_ALIGNED: begin
            if (ev_fit) begin
              state_d = FS_DECIDE;
            end else begin
              idx_d = idx_q + COne;
              if (ev_last) state_d = FS_DONE;
            end
          end
          default: begin
            if (bn_q == '0) begin
              state_d = FS_DECIDE;
            end else if (bn_q < ent_lo) begin
              res_d.status = STAT_HINT;
              state_d = FS_DONE;
            end else if (bn_q <= ent_hi) begin
              state_d = FS_DECIDE;
            end else begin
              idx_d = idx_q + COne;
              if (ev_last) state_d = FS_DONE;
            end
          end
        endcase
      end
      FS_DECIDE: begin
        sh_mode_d = pl_sh;
        sh_d      = pl_sh_start;
        sh_end_d  = pl_sh_end;
        w0_en_d   = pl_w0_en;
        w0_addr_d = pl_w0_addr;
        w0_data_d = pl_w0_data;
        w1_en_d   = pl_w1_en;
        w1_addr_d = pl_w1_addr;
        w1_data_d = pl_w1_data;
        res_d.status = pl_status;
        if (pl_status != STAT_OK) begin
          res_d.start_block = '0;
          res_d.blocks_left = (act_q == ACT_EXTENT) ? cnt_q[31:0] : '0;
          state_d = FS_DONE;
        end else begin
          res_d.start_block = pl_start[31:0];
          res_d.blocks_left = pl_left[31:0];
          res_d.free_total  = pl_total;
          count_nx_d = pl_count;
          total_nx_d = pl_total;
          if (pl_sh != SH_NONE) begin
            state_d = FS_SH_RD;
          end else if (pl_w0_en) begin
            state_d = FS_WR0;
          end else begin
            state_d = FS_DONE;
          end
        end
      end
      FS_SH_RD: begin
        mem_raddr = sh_q[IdxW-1:0];
        state_d   = FS_SH_WR;
      end
      FS_SH_WR: begin
        // move the entry read last cycle one slot toward the open end
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_waddr = (sh_mode_q == SH_OPEN) ? (sh_q[IdxW-1:0] + IdxW'(1))
                                           : (sh_q[IdxW-1:0] - IdxW'(1));
        if (sh_q == sh_end_q) begin
          state_d = w0_en_q ? FS_WR0 : FS_DONE;
        end else begin
          sh_d    = (sh_mode_q == SH_OPEN) ? (sh_q - COne) : (sh_q + COne);
          state_d = FS_SH_RD;
        end
      end
      FS_WR0: begin
        mem_we  = 1'b1;
        state_d = w1_en_q ? FS_WR1 : FS_DONE;
      end
      FS_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = w1_addr_q[IdxW-1:0];
        mem_wdata = w1_data_q;
        state_d   = FS_DONE;
      end
      FS_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          count_d     = count_nx_q;
          total_d     = total_nx_q;
          state_d     = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    bn_q       <= bn_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    prev_lo_q  <= prev_lo_d;
    prev_hi_q  <= prev_hi_d;
    prev_v_q   <= prev_v_d;
    cur_lo_q   <= cur_lo_d;
    cur_hi_q   <= cur_hi_d;
    cur_v_q    <= cur_v_d;
    sh_mode_q  <= sh_mode_d;
    sh_q       <= sh_d;
    sh_end_q   <= sh_end_d;
    w0_en_q    <= w0_en_d;
    w0_addr_q  <= w0_addr_d;
    w0_data_q  <= w0_data_d;
    w1_en_q    <= w1_en_d;
    w1_addr_q  <= w1_addr_d;
    w1_data_q  <= w1_data_d;
    res_q      <= res_d;
    count_nx_q <= count_nx_d;
    total_nx_q <= total_nx_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MaxCnt)
    else $error("range count above table depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_SH_RD && sh_mode_q == SH_OPEN) |-> (count_q < MaxCnt))
    else $error("insert shift on a full table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_DONE && out_valid_q && !out_ready_i) |=> (state_q == FS_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
